FILE: src/hds_pkg.sv
// Shared types, codes and fixed-point helpers for the heat diffusion stencil block.
package hds_pkg;

  // Request codes
  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_DIFFUS  = 3'd2;
  localparam logic [2:0] CFG_LOSS    = 3'd3;
  localparam logic [2:0] CFG_TSTEP   = 3'd4;
  localparam logic [2:0] CFG_AMBIENT = 3'd5;

  typedef logic signed [31:0] q16_t;      // signed Q16.16
  typedef logic [15:0]        frac16_t;   // unsigned Q0.16
  typedef logic signed [53:0] prod_t;     // product at scale 2^-32

  localparam prod_t ROUND_HALF = 54'sd32768;

  // Saturate a widened sum to the signed 32-bit range
  function automatic q16_t sat32(input logic signed [38:0] v);
    logic signed [38:0] hi;
    logic signed [38:0] lo;
    hi = 39'sd2147483647;
    lo = -39'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: src/heat_diffusion_stencil_step_top.sv
// Top level of the heat diffusion stencil block: grids, sequencer and shared multiplier.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | input     | in_valid / in_stall   | req_type, cell_x, cell_y, heat_amount
//  out     | output    | out_valid / out_stall | temperature, peak_temperature, status
//  cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// A step request walks every cell of the configured grid in raster order: three reads (the
// cell and its right and down neighbours) through one grid RAM read port, three products
// through one shared multiplier, then saturation and write-back.
// After reset a clearing pass over all MAX_WIDTH * MAX_HEIGHT addresses zeroes both grids;
// requests are stalled during it. A result waits in the output register while out_stall is
// high; the next request is accepted meanwhile and holds its result until the register frees.
module heat_diffusion_stencil_step_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [7:0]          cell_x,
  input  logic [7:0]          cell_y,
  input  hds_pkg::q16_t       heat_amount,
  output logic                out_valid,
  input  logic                out_stall,
  output hds_pkg::q16_t       temperature,
  output hds_pkg::q16_t       peak_temperature,
  output logic                status,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  import hds_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_DONE  = 4'd3;
  localparam logic [3:0] S_C0    = 4'd4;
  localparam logic [3:0] S_C1    = 4'd5;
  localparam logic [3:0] S_C2    = 4'd6;
  localparam logic [3:0] S_C3    = 4'd7;
  localparam logic [3:0] S_M0    = 4'd8;
  localparam logic [3:0] S_M1    = 4'd9;
  localparam logic [3:0] S_M2    = 4'd10;
  localparam logic [3:0] S_M3    = 4'd11;
  localparam logic [3:0] S_M4    = 4'd12;
  localparam logic [3:0] S_M5    = 4'd13;
  localparam logic [3:0] S_SAT   = 4'd14;
  localparam logic [3:0] S_WB    = 4'd15;

  // Configuration registers
  logic [DW-1:0] grid_w;
  logic [HW-1:0] grid_h;
  frac16_t       diffus;
  frac16_t       loss;
  frac16_t       tstep;
  q16_t          amb;

  logic [3:0]    state;
  logic [AW-1:0] clr_addr;

  // Request registers
  logic [1:0]    req_q;
  logic [AW-1:0] acc_addr;
  q16_t          amount_q;

  // Grid walk counters
  logic [CW-1:0] cx;
  logic [RW-1:0] cy;
  logic [AW-1:0] row_base;
  logic [AW-1:0] idx;

  // Cell datapath
  q16_t               t_old;
  q16_t               pk_old;
  q16_t               up_v;
  q16_t               right_v;
  q16_t               left_old;
  logic signed [35:0] lap;
  prod_t              prod;
  prod_t              acc;
  logic signed [36:0] rnd;
  logic signed [37:0] dlt;
  q16_t               nt;

  // Shared multiplier operands
  logic signed [36:0] mul_a;
  logic signed [16:0] mul_b;

  // Result holding and output registers
  q16_t res_temp;
  q16_t res_peak;
  logic res_status;

  // RAM ports
  logic          t_we;
  logic [AW-1:0] t_waddr;
  logic [31:0]   t_wdata;
  logic [AW-1:0] t_raddr;
  logic [31:0]   t_rdata;
  logic          p_we;
  logic [AW-1:0] p_waddr;
  logic [31:0]   p_wdata;
  logic [AW-1:0] p_raddr;
  logic [31:0]   p_rdata;
  logic          r_we;
  logic [31:0]   r_rdata;

  logic          in_fire;
  logic          in_grid;
  logic [AW-1:0] req_addr;
  logic          right_in;
  logic          down_in;
  logic          last_col;
  logic          last_row;
  logic          out_load;
  q16_t          left_v;
  q16_t          down_v;
  q16_t          add_sum;
  prod_t         acc_bias;
  prod_t         prod_bias;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign in_grid  = (32'(cell_x) < 32'(grid_w)) && (32'(cell_y) < 32'(grid_h));
  assign req_addr = AW'(AW'(cell_y) * MAX_WIDTH) + AW'(cell_x);
  assign idx      = row_base + AW'(cx);
  assign right_in = (32'(cx) + 32'd1) < 32'(grid_w);
  assign down_in  = (32'(cy) + 32'd1) < 32'(grid_h);
  assign last_col = !right_in;
  assign last_row = !down_in;
  assign left_v   = (cx != '0) ? left_old : amb;
  assign down_v   = down_in ? $signed(t_rdata) : amb;
  assign add_sum  = sat32(39'($signed(t_rdata)) + 39'(amount_q));
  assign acc_bias  = acc + ROUND_HALF;
  assign prod_bias = prod + ROUND_HALF;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // Configuration writes, with grid sizes clamped to the supported range
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= DW'(W_RST);
      grid_h <= HW'(H_RST);
      diffus <= '0;
      loss   <= '0;
      tstep  <= '0;
      amb    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          if (cfg_data[8:0] == 9'd0) begin
            grid_w <= DW'(1);
          end else if (32'(cfg_data[8:0]) > 32'(MAX_WIDTH)) begin
            grid_w <= DW'(MAX_WIDTH);
          end else begin
            grid_w <= DW'(cfg_data[8:0]);
          end
        end
        CFG_HEIGHT: begin
          if (cfg_data[8:0] == 9'd0) begin
            grid_h <= HW'(1);
          end else if (32'(cfg_data[8:0]) > 32'(MAX_HEIGHT)) begin
            grid_h <= HW'(MAX_HEIGHT);
          end else begin
            grid_h <= HW'(cfg_data[8:0]);
          end
        end
        CFG_DIFFUS:  diffus <= cfg_data[15:0];
        CFG_LOSS:    loss   <= cfg_data[15:0];
        CFG_TSTEP:   tstep  <= cfg_data[15:0];
        CFG_AMBIENT: amb    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Select operands of the shared multiplier
  always_comb begin
    case (state)
      S_M1: begin
        mul_a = 37'(33'(t_old) - 33'(amb));
        mul_b = $signed({1'b0, loss});
      end
      S_M4: begin
        mul_a = rnd;
        mul_b = $signed({1'b0, tstep});
      end
      default: begin
        mul_a = 37'(lap);
        mul_b = $signed({1'b0, diffus});
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (req_type == REQ_STEP) begin
              state <= S_C0;
            end else if ((req_type == REQ_ADD || req_type == REQ_READ) && in_grid) begin
              state <= S_ACC;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ACC:  state <= S_DONE;
        S_DONE: if (out_load) state <= S_IDLE;
        S_C0:   state <= S_C1;
        S_C1:   state <= S_C2;
        S_C2:   state <= S_C3;
        S_C3:   state <= S_M0;
        S_M0:   state <= S_M1;
        S_M1:   state <= S_M2;
        S_M2:   state <= S_M3;
        S_M3:   state <= S_M4;
        S_M4:   state <= S_M5;
        S_M5:   state <= S_SAT;
        S_SAT:  state <= S_WB;
        S_WB:   state <= (last_col && last_row) ? S_DONE : S_C0;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request capture, grid walk and cell arithmetic
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req_q    <= req_type;
        acc_addr <= req_addr;
        amount_q <= heat_amount;
        cx       <= '0;
        cy       <= '0;
        row_base <= '0;
        res_temp <= '0;
        res_peak <= '0;
        if (req_type == REQ_STEP) begin
          res_status <= STATUS_OK;
        end else if ((req_type == REQ_ADD || req_type == REQ_READ) && in_grid) begin
          res_status <= STATUS_OK;
        end else begin
          res_status <= STATUS_IGNORED;
        end
      end
      S_ACC: begin
        res_temp <= (req_q == REQ_ADD) ? add_sum : $signed(t_rdata);
        res_peak <= $signed(p_rdata);
      end
      S_C1: begin
        t_old  <= $signed(t_rdata);
        pk_old <= $signed(p_rdata);
        up_v   <= (cy != '0) ? $signed(r_rdata) : amb;
      end
      S_C2: right_v <= right_in ? $signed(t_rdata) : amb;
      S_C3: lap <= 36'(up_v) + 36'(left_v) + 36'(right_v) + 36'(down_v) - (36'(t_old) <<< 2);
      S_M0: prod <= 54'(mul_a * mul_b);
      S_M1: begin
        acc  <= prod;
        prod <= 54'(mul_a * mul_b);
      end
      S_M2: acc <= acc - prod;
      S_M3: rnd <= acc_bias[52:16];
      S_M4: prod <= 54'(mul_a * mul_b);
      S_M5: dlt <= prod_bias[53:16];
      S_SAT: nt <= sat32(39'(t_old) + 39'(dlt));
      S_WB: begin
        // Advance to the next cell in raster order
        left_old <= t_old;
        if (last_col) begin
          cx       <= '0;
          cy       <= cy + RW'(1);
          row_base <= row_base + AW'(MAX_WIDTH);
        end else begin
          cx <= cx + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      temperature      <= res_temp;
      peak_temperature <= res_peak;
      status           <= res_status;
    end
  end

  // Temperature grid ports
  always_comb begin
    t_we    = 1'b0;
    t_waddr = idx;
    t_wdata = nt;
    if (state == S_CLEAR) begin
      t_we    = 1'b1;
      t_waddr = clr_addr;
      t_wdata = '0;
    end else if (state == S_ACC && req_q == REQ_ADD) begin
      t_we    = 1'b1;
      t_waddr = acc_addr;
      t_wdata = add_sum;
    end else if (state == S_WB) begin
      t_we = 1'b1;
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  t_raddr = req_addr;
      S_C1:    t_raddr = idx + AW'(1);
      S_C2:    t_raddr = idx + AW'(MAX_WIDTH);
      default: t_raddr = idx;
    endcase
  end

  // Peak grid ports: keep the running maximum
  assign p_we    = (state == S_CLEAR) || (state == S_WB && nt > pk_old);
  assign p_waddr = (state == S_CLEAR) ? clr_addr : idx;
  assign p_wdata = (state == S_CLEAR) ? '0 : nt;
  assign p_raddr = (state == S_IDLE) ? req_addr : idx;

  assign r_we = (state == S_WB);

  hds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_temp_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (t_wdata),
    .rd_addr (t_raddr),
    .rd_data (t_rdata)
  );

  hds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_peak_ram (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .rd_addr (p_raddr),
    .rd_data (p_rdata)
  );

  // Old values of the row above
  hds_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_ram (
    .clk     (clk),
    .wr_en   (r_we),
    .wr_addr (cx),
    .wr_data (t_old),
    .rd_addr (cx),
    .rd_data (r_rdata)
  );

  // Ignored requests report zero values
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_IGNORED |-> temperature == 0 && peak_temperature == 0)
    else $error("ignored request returned nonzero data");

  // Walk counters stay inside the configured grid
  a_walk_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_C0 || state == S_WB |-> 32'(cx) < 32'(grid_w) && 32'(cy) < 32'(grid_h))
    else $error("grid walk left the configured grid");

  // An accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != S_IDLE)
    else $error("request accepted without starting work");

  // No result appears during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result during clearing pass");

endmodule

FILE: src/hds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
